FILE: src/assert_macros.svh
// Assertion macros for the top-level RTL file of the least loaded port selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LLPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define LLPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/llps_pkg.sv
// Package: shared types, codes and constants of the least loaded port selector.
package llps_pkg;

  localparam int unsigned PortsDefault = 16;
  localparam int unsigned LoadW        = 32;
  localparam int unsigned CmpW         = 9;

  localparam logic [2:0] REQ_ADD_TX  = 3'd0;
  localparam logic [2:0] REQ_ADD_RX  = 3'd1;
  localparam logic [2:0] REQ_SUB_TX  = 3'd2;
  localparam logic [2:0] REQ_SUB_RX  = 3'd3;
  localparam logic [2:0] REQ_MIN_TX  = 3'd4;
  localparam logic [2:0] REQ_MIN_RX  = 3'd5;
  localparam logic [2:0] REQ_MIN_SUM = 3'd6;

  localparam logic [0:0] REG_ACTIVE_PORTS = 1'b0;
  localparam logic [4:0] ActiveReset      = 5'd16;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MIN_ONE,
    ALU_MIN_SUM
  } alu_op_e;

  typedef struct packed {
    alu_op_e op;
    logic    use_rx;
  } alu_ctl_t;

endpackage

FILE: src/least_loaded_port_selector.sv
// Top level: least loaded port selector with config port, sequencer and load stores.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | in        | in_valid_i/stall_o | req_type_i, port_id_i, delta_i
//  out     | out       | out_valid_o/stall_i| chosen_port_o, found_o
//  cfg     | in        | APB psel/penable   | paddr, pwdata, prdata
//
// Update: read, then write back through the shared adder.
// Query: scans min(active_ports, PORTS) ports, one port per cycle through the
//   shared adder/comparator; the rate is set by the single read port of each load store.
// Reset clears the loads through per-entry valid bits; no clearing pass.
// A finished result waits in the output register; a new item is taken meanwhile.
`include "assert_macros.svh"

module least_loaded_port_selector #(
  parameter int unsigned PORTS = llps_pkg::PortsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  port_id_i,
  input  logic [31:0] delta_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  chosen_port_o,
  output logic        found_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int unsigned CmpW = llps_pkg::CmpW;
  localparam int unsigned LoadW = llps_pkg::LoadW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [4:0]            active_q;
  logic [2:0]            req_q;
  logic [IdxW-1:0]       port_q;
  logic [LoadW-1:0]      delta_q;
  logic [IdxW-1:0]       cnt_q, cnt_d;
  logic signed [LoadW:0] best_q, best_d;
  logic [IdxW-1:0]       best_id_q, best_id_d;
  logic                  hit_q, hit_d;
  logic                  out_valid_q;
  logic [3:0]            chosen_q;
  logic                  found_q;

  logic                  in_acc;
  logic                  is_upd;
  logic                  is_qry;
  logic [CmpW-1:0]       live_n;
  logic [IdxW-1:0]       raddr;
  logic [LoadW-1:0]      tx_rd, rx_rd;
  logic                  tx_we, rx_we;
  logic                  use_rx;
  llps_pkg::alu_ctl_t    alu_ctl;
  logic [LoadW:0]        alu_res;
  logic                  alu_less;
  logic                  last;
  logic                  out_load;

  // Config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == llps_pkg::REG_ACTIVE_PORTS) ? {27'd0, active_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= llps_pkg::ActiveReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == llps_pkg::REG_ACTIVE_PORTS) begin
      active_q <= pwdata[4:0];
    end
  end

  assign live_n = ({4'd0, active_q} > CmpW'(PORTS)) ? CmpW'(PORTS) : {4'd0, active_q};

  // Request decode
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_upd     = (req_type_i <= llps_pkg::REQ_SUB_RX) && ({1'b0, port_id_i} < live_n);
  assign is_qry     = (req_type_i >= llps_pkg::REQ_MIN_TX) &&
                      (req_type_i <= llps_pkg::REQ_MIN_SUM);

  assign use_rx = (req_q == llps_pkg::REQ_ADD_RX) || (req_q == llps_pkg::REQ_SUB_RX) ||
                  (req_q == llps_pkg::REQ_MIN_RX);

  always_comb begin
    alu_ctl.use_rx = use_rx;
    unique case (req_q) inside
      llps_pkg::REQ_ADD_TX, llps_pkg::REQ_ADD_RX: alu_ctl.op = llps_pkg::ALU_ADD;
      llps_pkg::REQ_SUB_TX, llps_pkg::REQ_SUB_RX: alu_ctl.op = llps_pkg::ALU_SUB;
      llps_pkg::REQ_MIN_SUM:                      alu_ctl.op = llps_pkg::ALU_MIN_SUM;
      default:                                    alu_ctl.op = llps_pkg::ALU_MIN_ONE;
    endcase
  end

  // Read address: next port while scanning, else first port or update target
  always_comb begin
    if (state_q == S_SCAN) begin
      raddr = cnt_q + IdxW'(1);
    end else if (is_qry) begin
      raddr = '0;
    end else begin
      raddr = port_id_i[IdxW-1:0];
    end
  end

  assign tx_we = (state_q == S_UPD) && !use_rx;
  assign rx_we = (state_q == S_UPD) && use_rx;

  llps_load_mem #(
    .DEPTH (PORTS)
  ) u_tx_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tx_we),
    .waddr_i (port_q),
    .wdata_i (alu_res[LoadW-1:0]),
    .raddr_i (raddr),
    .rdata_o (tx_rd)
  );

  llps_load_mem #(
    .DEPTH (PORTS)
  ) u_rx_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (rx_we),
    .waddr_i (port_q),
    .wdata_i (alu_res[LoadW-1:0]),
    .raddr_i (raddr),
    .rdata_o (rx_rd)
  );

  llps_alu u_alu (
    .ctl_i   (alu_ctl),
    .tx_i    (tx_rd),
    .rx_i    (rx_rd),
    .delta_i (delta_q),
    .best_i  (best_q),
    .res_o   (alu_res),
    .less_o  (alu_less)
  );

  assign last     = (CmpW'(cnt_q) == live_n - CmpW'(1));
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    best_d    = best_q;
    best_id_d = best_id_q;
    hit_d     = hit_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cnt_d     = '0;
          best_d    = {2'b00, {(LoadW-1){1'b1}}};
          best_id_d = '0;
          hit_d     = 1'b0;
          if (is_upd) begin
            state_d = S_UPD;
          end else if (is_qry) begin
            state_d = (live_n == '0) ? S_DONE : S_SCAN;
          end
        end
      end
      S_UPD: begin
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (alu_less) begin
          best_d    = $signed(alu_res);
          best_id_d = cnt_q;
          hit_d     = 1'b1;
        end
        cnt_d = cnt_q + IdxW'(1);
        if (last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    best_q    <= best_d;
    best_id_q <= best_id_d;
    hit_q     <= hit_d;
    if (in_acc) begin
      req_q   <= req_type_i;
      port_q  <= port_id_i[IdxW-1:0];
      delta_q <= delta_i;
    end
    if (out_load) begin
      chosen_q <= 4'(best_id_q);
      found_q  <= hit_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign chosen_port_o = chosen_q;
  assign found_o       = found_q;

  `LLPS_ASSERT(a_one_store_written, clk_i, rst_ni, !(tx_we && rx_we), "both stores written")
  `LLPS_ASSERT_IMP(a_no_write_in_scan, clk_i, rst_ni, state_q == S_SCAN, !tx_we && !rx_we, "store written during scan")
  `LLPS_ASSERT_IMP(a_scan_in_range, clk_i, rst_ni, state_q == S_SCAN, CmpW'(cnt_q) < live_n, "scan index beyond active ports")
  `LLPS_ASSERT_IMP(a_none_is_zero, clk_i, rst_ni, out_valid_o && !found_o, chosen_port_o == 4'd0, "port reported with no hit")

endmodule

FILE: src/llps_load_mem.sv
// Load store: one write port, one registered read port, per-entry valid bits.
module llps_load_mem #(
  parameter int unsigned DEPTH = llps_pkg::PortsDefault
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [llps_pkg::LoadW-1:0]                   wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [llps_pkg::LoadW-1:0]                   rdata_o
);

  logic [llps_pkg::LoadW-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           vld_q;
  logic [llps_pkg::LoadW-1:0] rdata_q;
  logic                       rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

FILE: src/llps_alu.sv
// Shared 33-bit add/subtract unit with signed compare against the running minimum.
module llps_alu (
  input  llps_pkg::alu_ctl_t          ctl_i,
  input  logic [llps_pkg::LoadW-1:0]  tx_i,
  input  logic [llps_pkg::LoadW-1:0]  rx_i,
  input  logic [llps_pkg::LoadW-1:0]  delta_i,
  input  logic signed [llps_pkg::LoadW:0] best_i,
  output logic [llps_pkg::LoadW:0]    res_o,
  output logic                        less_o
);

  logic [llps_pkg::LoadW:0] x;
  logic [llps_pkg::LoadW:0] y;
  logic                     cin;

  always_comb begin
    x   = ctl_i.use_rx ? {rx_i[llps_pkg::LoadW-1], rx_i} : {tx_i[llps_pkg::LoadW-1], tx_i};
    y   = '0;
    cin = 1'b0;
    case (ctl_i.op)
      llps_pkg::ALU_ADD: begin
        y = {delta_i[llps_pkg::LoadW-1], delta_i};
      end
      llps_pkg::ALU_SUB: begin
        y   = ~{delta_i[llps_pkg::LoadW-1], delta_i};
        cin = 1'b1;
      end
      llps_pkg::ALU_MIN_SUM: begin
        x = {tx_i[llps_pkg::LoadW-1], tx_i};
        y = {rx_i[llps_pkg::LoadW-1], rx_i};
      end
      default: begin
        y = '0;
      end
    endcase
  end

  assign res_o  = x + y + {{llps_pkg::LoadW{1'b0}}, cin};
  assign less_o = $signed(res_o) < best_i;

endmodule

FILE: verif/testbench.sv
// Testbench for the least loaded port selector: random updates and queries checked per result.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned PortCount   = llps_pkg::PortsDefault;
  localparam logic [2:0]  REQ_UNUSED  = 3'd7;
  localparam logic [2:0]  ActiveAddr  = 3'(4 * llps_pkg::REG_ACTIVE_PORTS);
  localparam int          SettleCycles = PortCount + 8;
  localparam int          HoldCycles  = 300;
  localparam int          IdleLimit   = 4000;

  typedef struct {
    logic [2:0]  req;
    logic [7:0]  port;
    logic [31:0] delta;
    bit          aim_top;
  } port_req_t;

  typedef struct {
    logic [3:0] port;
    logic       found;
  } pick_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  req_type_i = llps_pkg::REQ_ADD_TX;
  logic [7:0]  port_id_i = 8'd0;
  logic [31:0] delta_i = 32'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  chosen_port_o;
  logic        found_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  least_loaded_port_selector dut (.*);

  always #6 clk_i = ~clk_i;

  port_req_t   pending[$];
  pick_t       pick_q[$];
  logic [31:0] tx_shadow[PortCount];
  logic [31:0] rx_shadow[PortCount];
  logic [4:0]  port_limit = llps_pkg::ActiveReset;

  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;
  bit hold_started = 1'b0;
  int hold_cnt = 0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int n_items = 0;
  int n_picks = 0;
  int n_none = 0;
  int n_settings = 0;

  function automatic int live_ports();
    return (port_limit > PortCount) ? PortCount : int'(port_limit);
  endfunction

  // Update the shadow loads, or queue the pick a query must return.
  function automatic void apply_request(logic [2:0] req, logic [7:0] port, logic [31:0] delta);
    longint best;
    longint v;
    int     pick;
    bit     hit;
    int     n;
    n = live_ports();
    best = 64'sd2147483647;
    pick = 0;
    hit = 1'b0;
    case (req) inside
      llps_pkg::REQ_ADD_TX: if (port < n) tx_shadow[port] += delta;
      llps_pkg::REQ_ADD_RX: if (port < n) rx_shadow[port] += delta;
      llps_pkg::REQ_SUB_TX: if (port < n) tx_shadow[port] -= delta;
      llps_pkg::REQ_SUB_RX: if (port < n) rx_shadow[port] -= delta;
      llps_pkg::REQ_MIN_TX, llps_pkg::REQ_MIN_RX, llps_pkg::REQ_MIN_SUM: begin
        for (int i = 0; i < n; i++) begin
          if (req == llps_pkg::REQ_MIN_TX) v = longint'($signed(tx_shadow[i]));
          else if (req == llps_pkg::REQ_MIN_RX) v = longint'($signed(rx_shadow[i]));
          else v = longint'($signed(tx_shadow[i])) + longint'($signed(rx_shadow[i]));
          if (v < best) begin
            best = v;
            pick = i;
            hit = 1'b1;
          end
        end
        pick_q.push_back('{port: hit ? 4'(pick) : 4'd0, found: hit});
      end
      default: ;
    endcase
  endfunction

  // Delta that brings the addressed load exactly to the top value.
  function automatic logic [31:0] top_delta(port_req_t r);
    logic [31:0] cur;
    cur = (r.req == llps_pkg::REQ_ADD_TX || r.req == llps_pkg::REQ_SUB_TX) ?
          tx_shadow[r.port[3:0]] : rx_shadow[r.port[3:0]];
    return (r.req == llps_pkg::REQ_ADD_TX || r.req == llps_pkg::REQ_ADD_RX) ?
           32'h7FFF_FFFF - cur : cur - 32'h7FFF_FFFF;
  endfunction

  function automatic void push_req(logic [2:0] req, logic [7:0] port, logic [31:0] delta,
                                   bit aim = 1'b0);
    pending.push_back('{req: req, port: port, delta: delta, aim_top: aim});
  endfunction

  function automatic void add_random(int n);
    int          k;
    int          live;
    logic [2:0]  req;
    logic [7:0]  port;
    logic [31:0] delta;
    bit          aim;
    live = live_ports();
    for (int j = 0; j < n; j++) begin
      k = $urandom_range(0, 99);
      aim = 1'b0;
      if (k < 6) req = REQ_UNUSED;
      else if (k < 55) req = 3'($urandom_range(0, 3));
      else req = 3'($urandom_range(4, 6));
      if ($urandom_range(0, 6) == 0) port = 8'($urandom);
      else port = 8'($urandom_range(0, live + 1));
      k = $urandom_range(0, 15);
      if (k < 9) begin
        delta = 32'(int'($urandom_range(0, 40)) - 20);
      end else if (k < 12) begin
        delta = $urandom;
      end else if (k < 14) begin
        case ($urandom_range(0, 3))
          0: delta = 32'h8000_0000;
          1: delta = 32'h7FFF_FFFF;
          2: delta = 32'hFFFF_FFFF;
          default: delta = 32'h0;
        endcase
      end else begin
        delta = $urandom;
        aim = (req <= llps_pkg::REQ_SUB_RX);
      end
      push_req(req, port, delta, aim);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 40)
      $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic write_active(logic [4:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ActiveAddr;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    port_limit = value;
    n_settings++;
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_valid_i || pick_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_request(req_type_i, port_id_i, delta_i);
        n_items++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
          in_gap <= $urandom_range(0, 5);
          in_valid_i <= 1'b0;
        end else if (pending.size() != 0) begin
          req_type_i <= pending[0].req;
          port_id_i <= pending[0].port;
          delta_i <= pending[0].aim_top ? top_delta(pending[0]) : pending[0].delta;
          void'(pending.pop_front());
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor and result checker.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pick_q.size() == 0) begin
          report_mismatch("unexpected result, port", chosen_port_o, 0);
        end else begin
          if (found_o !== pick_q[0].found)
            report_mismatch("found", found_o, pick_q[0].found);
          if (chosen_port_o !== pick_q[0].port)
            report_mismatch("chosen_port", chosen_port_o, pick_q[0].port);
          if (!pick_q[0].found) n_none++;
          void'(pick_q.pop_front());
        end
        n_picks++;
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall_i <= 1'b1;
      end else if (long_hold_req && !hold_started) begin
        hold_started <= 1'b1;
        hold_cnt <= HoldCycles;
        out_stall_i <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("least_loaded_port_selector verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < PortCount; i++) begin
      tx_shadow[i] = 32'd0;
      rx_shadow[i] = 32'd0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state, wrap, ignored updates and ties, with all ports active.
    push_req(llps_pkg::REQ_MIN_TX, 8'd0, 32'd0);
    push_req(llps_pkg::REQ_MIN_RX, 8'hFF, 32'hFFFF_FFFF);
    push_req(llps_pkg::REQ_MIN_SUM, 8'd0, 32'd0);
    push_req(llps_pkg::REQ_ADD_TX, 8'd3, 32'hFFFF_FFFB);
    push_req(llps_pkg::REQ_ADD_RX, 8'd15, 32'h8000_0000);
    push_req(llps_pkg::REQ_ADD_TX, 8'hFF, 32'd100);
    push_req(llps_pkg::REQ_ADD_RX, 8'd16, 32'hFFFF_FF9C);
    push_req(REQ_UNUSED, 8'd0, 32'hFFFF_FC18);
    push_req(llps_pkg::REQ_MIN_TX, 8'd0, 32'd0);
    push_req(llps_pkg::REQ_MIN_RX, 8'd0, 32'd0);
    push_req(llps_pkg::REQ_MIN_SUM, 8'd0, 32'd0);
    push_req(llps_pkg::REQ_SUB_TX, 8'd3, 32'h8000_0000);
    push_req(llps_pkg::REQ_SUB_RX, 8'd15, 32'd1);
    push_req(llps_pkg::REQ_MIN_TX, 8'd0, 32'd0);
    push_req(llps_pkg::REQ_MIN_RX, 8'd0, 32'd0);
    push_req(llps_pkg::REQ_MIN_SUM, 8'd0, 32'd0);
    push_req(llps_pkg::REQ_ADD_TX, 8'd7, 32'h7FFF_FFFF);
    push_req(llps_pkg::REQ_SUB_RX, 8'd0, 32'hFFFF_FFFF);
    push_req(llps_pkg::REQ_ADD_RX, 8'd8, 32'h5555_5555);
    push_req(llps_pkg::REQ_ADD_TX, 8'd9, 32'hAAAA_AAAA);
    push_req(llps_pkg::REQ_MIN_TX, 8'd0, 32'd0);
    push_req(llps_pkg::REQ_MIN_RX, 8'd0, 32'd0);
    push_req(llps_pkg::REQ_MIN_SUM, 8'd0, 32'd0);
    drain();

    // Random traffic while the receiver holds off for a long stretch.
    add_random(180);
    long_hold_req <= 1'b1;
    drain();

    write_active(5'd31);
    add_random(130);
    drain();

    // Single port: load at the top value never qualifies.
    write_active(5'd1);
    push_req(llps_pkg::REQ_ADD_TX, 8'd0, 32'd0, 1'b1);
    push_req(llps_pkg::REQ_MIN_TX, 8'd0, 32'd0);
    push_req(llps_pkg::REQ_MIN_RX, 8'd0, 32'd0);
    push_req(llps_pkg::REQ_MIN_SUM, 8'd0, 32'd0);
    add_random(90);
    drain();

    write_active(5'd0);
    add_random(40);
    drain();

    write_active(5'd5);
    add_random(130);
    drain();

    write_active(5'd17);
    add_random(130);
    drain();

    write_active(5'd2);
    add_random(90);
    drain();

    write_active(5'd16);
    add_random(130);
    drain();

    write_active(5'($urandom_range(0, 31)));
    add_random(100);
    drain();

    // Closing stretch at full rate.
    write_active(5'd16);
    quiet <= 1'b1;
    add_random(120);
    drain();

    $display("Covered %0d items and %0d query results (%0d with no port found)",
             n_items, n_picks, n_none);
    $display("across %0d port-count settings, including 0, 1, 16 and 31", n_settings);
    if (mismatches == 0 && pick_q.size() == 0)
      $display("least_loaded_port_selector verification clean");
    else
      $display("least_loaded_port_selector verification failed");
    $finish;
  end

endmodule

FILE: least_loaded_port_selector.f
+incdir+src
src/llps_pkg.sv
src/llps_load_mem.sv
src/llps_alu.sv
src/least_loaded_port_selector.sv
verif/testbench.sv
